// File: hdl/pan_pkg.sv
// Package for the polygon area and normal block.
// Holds the shared widths, payload structs, state enums and axis codes.
// No dependencies.
`default_nettype none
package pan_pkg;

    localparam int COORD_BITS     = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int SUM_W          = 64;
    localparam int AREA_W         = 48;
    localparam int UNIT_W         = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vx;
        logic signed [COORD_BITS-1:0] vy;
        logic signed [COORD_BITS-1:0] vz;
        logic                         last_vertex;
    } vertex_t;

    typedef struct packed {
        logic [AREA_W-1:0]        face_area;
        logic signed [UNIT_W-1:0] unit_nx;
        logic signed [UNIT_W-1:0] unit_ny;
        logic signed [UNIT_W-1:0] unit_nz;
        logic [1:0]               dominant_axis;
        logic                     degenerate;
    } face_t;

    typedef logic [2:0][COORD_BITS-1:0] point_t;

    // Closed sums of one face, handed from front to back
    typedef struct packed {
        logic [2:0][SUM_W-1:0] newell;
        logic [2:0][SUM_W-1:0] proj;
        logic                  enough;
    } face_sums_t;

    typedef enum logic [2:0] {
        F_IDLE, F_EDGE, F_PROJ, F_CEDGE, F_CP1, F_CP2, F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_SHIFT, B_SQ, B_SQRT, B_DLOAD, B_DIV,
        B_AREA0, B_AREA1, B_AREA2, B_DONE
    } back_state_t;

endpackage
`default_nettype wire

// File: hdl/pan_front.sv
// Front end: takes vertices and accumulates Newell and projected sums.
// Depends on pan_pkg; feeds pan_queue.
`default_nettype none
module pan_front #(
    parameter int COUNT_BITS = pan_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vert_valid,
    output logic                  vert_stall,
    input  pan_pkg::vertex_t      vert,
    output logic                  push,
    output pan_pkg::face_sums_t   sums,
    input  logic                  queue_full
);
    import pan_pkg::*;

    localparam int OP_W   = COORD_BITS + 1;
    localparam int PROD_W = 2 * OP_W;

    front_state_t state_reg, state_next;
    point_t v_reg, first_reg, second_reg, prev_reg, bprev_reg;
    logic last_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [2:0][SUM_W-1:0] newell_reg, proj_reg;

    logic vert_accept;
    logic is_edge, add_en;
    point_t c, n, mid, nxt, prv;
    logic signed [OP_W-1:0] op_a [3];
    logic signed [OP_W-1:0] op_b [3];
    logic signed [PROD_W-1:0] prod [3];

    function automatic logic signed [OP_W-1:0] sx(input logic [COORD_BITS-1:0] x);
        sx = {x[COORD_BITS-1], x};
    endfunction

    assign vert_stall  = !(state_reg == F_IDLE || (state_reg == F_PROJ && !last_reg));
    assign vert_accept = vert_valid && !vert_stall;

    // operand selection and the three shared multipliers
    always_comb
    begin
        is_edge = (state_reg == F_EDGE) || (state_reg == F_CEDGE);
        c   = (state_reg == F_CEDGE) ? v_reg : prev_reg;
        n   = (state_reg == F_CEDGE) ? first_reg : v_reg;
        mid = prev_reg;
        nxt = v_reg;
        prv = bprev_reg;
        if (state_reg == F_CP1)
        begin
            mid = v_reg;
            nxt = first_reg;
            prv = bprev_reg;
        end
        else if (state_reg == F_CP2)
        begin
            mid = first_reg;
            nxt = second_reg;
            prv = v_reg;
        end
        if (is_edge)
        begin
            op_a[0] = sx(c[1]) - sx(n[1]);
            op_b[0] = sx(c[2]) + sx(n[2]);
            op_a[1] = sx(c[2]) - sx(n[2]);
            op_b[1] = sx(c[0]) + sx(n[0]);
            op_a[2] = sx(c[0]) - sx(n[0]);
            op_b[2] = sx(c[1]) + sx(n[1]);
        end
        else
        begin
            op_a[0] = sx(mid[1]);
            op_b[0] = sx(nxt[2]) - sx(prv[2]);
            op_a[1] = sx(mid[0]);
            op_b[1] = sx(nxt[2]) - sx(prv[2]);
            op_a[2] = sx(mid[0]);
            op_b[2] = sx(nxt[1]) - sx(prv[1]);
        end
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = op_a[i] * op_b[i];
        end
        case (state_reg)
            F_EDGE:  add_en = (count_reg >= COUNT_BITS'(1));
            F_PROJ:  add_en = (count_reg >= COUNT_BITS'(2));
            F_CEDGE, F_CP1, F_CP2: add_en = (count_reg >= COUNT_BITS'(3));
            default: add_en = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        push = 1'b0;
        case (state_reg)
            F_IDLE:  if (vert_accept) state_next = F_EDGE;
            F_EDGE:  state_next = F_PROJ;
            F_PROJ:
            begin
                if (last_reg)         state_next = F_CEDGE;
                else if (vert_accept) state_next = F_EDGE;
                else                  state_next = F_IDLE;
            end
            F_CEDGE: state_next = F_CP1;
            F_CP1:   state_next = F_CP2;
            F_CP2:   state_next = F_PUSH;
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    push = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign sums.newell = newell_reg;
    assign sums.proj   = proj_reg;
    assign sums.enough = (count_reg >= COUNT_BITS'(3));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            count_reg  <= '0;
            newell_reg <= '0;
            proj_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            prev_reg   <= '0;
            bprev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (add_en && is_edge)
            begin
                for (int i = 0; i < 3; i++)
                    newell_reg[i] <= newell_reg[i] + SUM_W'(prod[i]);
            end
            if (add_en && !is_edge)
            begin
                for (int i = 0; i < 3; i++)
                    proj_reg[i] <= proj_reg[i] + SUM_W'(prod[i]);
            end
            // vertex history and count move on after the projected term
            if (state_reg == F_PROJ)
            begin
                bprev_reg <= prev_reg;
                prev_reg  <= v_reg;
                if (count_reg == COUNT_BITS'(0)) first_reg  <= v_reg;
                if (count_reg == COUNT_BITS'(1)) second_reg <= v_reg;
                if (count_reg != '1) count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (push)
            begin
                count_reg  <= '0;
                newell_reg <= '0;
                proj_reg   <= '0;
                first_reg  <= '0;
                second_reg <= '0;
                prev_reg   <= '0;
                bprev_reg  <= '0;
            end
        end
    end

    // latched vertex
    always_ff @(posedge clk)
    begin
        if (vert_accept)
        begin
            v_reg    <= {vert.vz, vert.vy, vert.vx};
            last_reg <= vert.last_vertex;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pan_queue.sv
// Short queue of closed face sums between front and back.
// Depends on pan_pkg.
`default_nettype none
module pan_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pan_pkg::face_sums_t wr_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output pan_pkg::face_sums_t head
);
    import pan_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    face_sums_t entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full      = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (push && !pop)      fill_reg <= fill_reg + CNT_W'(1);
            else if (pop && !push) fill_reg <= fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule
`default_nettype wire

// File: hdl/pan_back.sv
// Back end: normalizes the Newell normal, picks the axis, scales the area.
// Depends on pan_pkg; takes entries from pan_queue.
`default_nettype none
module pan_back #(
    parameter int FRAC_BITS = pan_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  pan_pkg::face_sums_t q_head,
    output logic                pop,
    output logic                face_valid,
    input  logic                face_stall,
    output pan_pkg::face_t      face
);
    import pan_pkg::*;

    localparam int SH     = 31 + FRAC_BITS;
    localparam int FULL_W = 96;

    back_state_t state_reg, state_next;
    logic [SUM_W-1:0] r_reg [3];
    logic [2:0] neg_reg;
    logic [1:0] axis_reg;
    logic [SUM_W-1:0] p_reg;
    logic [1:0] idx_reg;
    logic [4:0] cnt_reg;
    logic [SUM_W-1:0] sqv_reg, root_reg, bit_reg;
    logic [31:0] den_reg, rem_reg, quo_reg;
    logic [31:0] mag_reg [3];
    logic [31:0] q_reg;
    logic [SUM_W-1:0] pa_reg, pb_reg;
    logic [FULL_W-1:0] full_reg;
    logic degen_reg;
    logic face_valid_reg;
    face_t face_reg;

    logic [SUM_W-1:0] a [3];
    logic [SUM_W-1:0] pabs [3];
    logic [1:0] axis_sel;
    logic is_degen;
    logic [SUM_W:0] rb;
    logic [32:0] trial;
    logic [62:0] num;
    logic [31:0] len;
    logic out_load;
    face_t face_next;

    function automatic logic [SUM_W-1:0] abs64(input logic [SUM_W-1:0] x);
        abs64 = x[SUM_W-1] ? (~x + SUM_W'(1)) : x;
    endfunction

    // classify the head entry
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a[i]    = abs64(q_head.newell[i]);
            pabs[i] = abs64(q_head.proj[i]);
        end
        if (a[0] > a[1]) axis_sel = (a[0] > a[2]) ? AXIS_X : AXIS_Z;
        else             axis_sel = (a[1] > a[2]) ? AXIS_Y : AXIS_Z;
        is_degen = !q_head.enough || ((a[0] | a[1] | a[2]) == '0);
    end

    // shared step logic
    assign len   = root_reg[31:0];
    assign rb    = {1'b0, root_reg} + {1'b0, bit_reg};
    assign trial = {rem_reg, quo_reg[31]};
    always_comb
    begin
        if (idx_reg == 2'd3)
            num = {1'b0, len, 30'b0};
        else
            num = 63'({r_reg[idx_reg][30:0], 30'b0}) + 63'(len >> 1);
    end

    // result assembly
    always_comb
    begin
        face_next = '0;
        face_next.degenerate = degen_reg;
        if (!degen_reg)
        begin
            face_next.face_area = (|(full_reg >> (SH + AREA_W))) ? '1
                                : AREA_W'(full_reg >> SH);
            face_next.unit_nx = neg_reg[0] ? mag_reg[0] : -mag_reg[0];
            face_next.unit_ny = neg_reg[1] ? mag_reg[1] : -mag_reg[1];
            face_next.unit_nz = neg_reg[2] ? mag_reg[2] : -mag_reg[2];
            face_next.dominant_axis = axis_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pop = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    state_next = is_degen ? B_DONE : B_SHIFT;
                end
            end
            B_SHIFT: if (r_reg[axis_reg][SUM_W-1:31] == '0) state_next = B_SQ;
            B_SQ:    if (cnt_reg == 5'd2) state_next = B_SQRT;
            B_SQRT:  if (cnt_reg == 5'd31) state_next = B_DLOAD;
            B_DLOAD: state_next = B_DIV;
            B_DIV:
            begin
                if (cnt_reg == 5'd31)
                    state_next = (idx_reg == 2'd3) ? B_AREA0 : B_DLOAD;
            end
            B_AREA0: state_next = B_AREA1;
            B_AREA1: state_next = B_AREA2;
            B_AREA2: state_next = B_DONE;
            B_DONE:
            begin
                if (!face_valid_reg || !face_stall)
                begin
                    out_load = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            face_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)        face_valid_reg <= 1'b1;
            else if (!face_stall) face_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r_reg[i]   <= a[i];
                    neg_reg[i] <= q_head.newell[i][SUM_W-1];
                end
                axis_reg  <= axis_sel;
                p_reg     <= pabs[axis_sel];
                degen_reg <= is_degen;
                cnt_reg   <= '0;
                sqv_reg   <= '0;
            end
            B_SHIFT:
            begin
                if (r_reg[axis_reg][SUM_W-1:31] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        r_reg[i] <= r_reg[i] >> 1;
                end
            end
            B_SQ:
            begin
                sqv_reg <= sqv_reg + SUM_W'(r_reg[cnt_reg[1:0]][30:0] *
                                            r_reg[cnt_reg[1:0]][30:0]);
                cnt_reg <= (cnt_reg == 5'd2) ? 5'd0 : cnt_reg + 5'd1;
                root_reg <= '0;
                bit_reg  <= SUM_W'(1) << 62;
            end
            B_SQRT:
            begin
                if ({1'b0, sqv_reg} >= rb)
                begin
                    sqv_reg  <= sqv_reg - rb[SUM_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                idx_reg <= 2'd0;
            end
            B_DLOAD:
            begin
                rem_reg <= num[62:32] == '0 ? 32'd0 : {1'b0, num[62:32]};
                quo_reg <= num[31:0];
                den_reg <= (idx_reg == 2'd3) ? r_reg[axis_reg][31:0] : len;
                cnt_reg <= '0;
            end
            B_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= 32'(trial - {1'b0, den_reg});
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    if (idx_reg == 2'd3)
                        q_reg <= {quo_reg[30:0], trial >= {1'b0, den_reg}};
                    else
                        mag_reg[idx_reg] <= {quo_reg[30:0], trial >= {1'b0, den_reg}};
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            B_AREA0: pa_reg <= p_reg[63:32] * q_reg;
            B_AREA1: pb_reg <= p_reg[31:0] * q_reg;
            B_AREA2: full_reg <= {pa_reg, 32'b0} + FULL_W'(pb_reg);
            default: ;
        endcase
        if (out_load) face_reg <= face_next;
    end

    assign face_valid = face_valid_reg;
    assign face       = face_reg;

endmodule
`default_nettype wire

// File: hdl/polygon_area_and_normal.sv
// Top level: Newell normal and area of a streamed planar polygon.
// In the front a vertex runs one multiply step for the edge term and one for
// the projected term; the last vertex adds the closing states CEDGE, CP1, CP2 and PUSH.
// Per face the back goes straight to output if degenerate, else runs 0 to 33 shift
// steps, the squaring steps, 32 square root steps, four divisions and the area steps.
// Reset (rst_n, async active low) clears the front sums and vertex count, the queue fill and face_valid.
`default_nettype none
module polygon_area_and_normal #(
    parameter int FRAC_BITS  = pan_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = pan_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vert_valid,
    output logic             vert_stall,
    input  pan_pkg::vertex_t vert,
    output logic             face_valid,
    input  logic             face_stall,
    output pan_pkg::face_t   face
);
    import pan_pkg::*;

    face_sums_t wr_entry, head;
    logic push, full, pop, not_empty;

    pan_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .vert_valid(vert_valid), .vert_stall(vert_stall), .vert(vert),
        .push(push), .sums(wr_entry), .queue_full(full)
    );

    pan_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .wr_entry(wr_entry), .full(full),
        .pop(pop), .not_empty(not_empty), .head(head)
    );

    pan_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(not_empty), .q_head(head), .pop(pop),
        .face_valid(face_valid), .face_stall(face_stall), .face(face)
    );

endmodule
`default_nettype wire

// File: dv/polygon_area_and_normal_tb.sv
// Testbench for polygon_area_and_normal: streams vertex transfers and checks face results.
// A directed table first, then random polygons; untyped faces are checked against a predictor.
// Depends on hdl/pan_pkg.sv and hdl/polygon_area_and_normal.sv.
`default_nettype none
module polygon_area_and_normal_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pan_pkg::*;

    localparam int      FRAC       = 16;
    localparam int      RAND_ITEMS = 1650;
    localparam int      CYCLE_CAP  = 4000000;
    localparam longint  AREA_SAT   = (64'd1 << 48) - 1;
    localparam int      CNT_SAT    = 65535;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    vert_valid = 1'b0;
    logic    vert_stall;
    vertex_t vert = '0;
    logic    face_valid;
    logic    face_stall = 1'b0;
    face_t   face;

    polygon_area_and_normal u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vert_stall (vert_stall),
        .vert       (vert),
        .face_valid (face_valid),
        .face_stall (face_stall),
        .face       (face)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state: one open polygon
    logic [63:0] newell [3];
    logic [63:0] proj [3];
    logic [63:0] first_pt [3];
    logic [63:0] second_pt [3];
    logic [63:0] prev_pt [3];
    logic [63:0] prev2_pt [3];
    int          vert_cnt;

    face_t       face_q [$];
    int          errors = 0;
    int          faces_seen = 0;
    int          verts_sent = 0;
    int          degen_seen = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void clear_face();
        for (int i = 0; i < 3; i++)
        begin
            newell[i] = 0;
            proj[i] = 0;
            first_pt[i] = 0;
            second_pt[i] = 0;
            prev_pt[i] = 0;
            prev2_pt[i] = 0;
        end
        vert_cnt = 0;
    endfunction

    function automatic void edge_term(input logic [63:0] c [3], input logic [63:0] n [3]);
        newell[0] += (c[1] - n[1]) * (c[2] + n[2]);
        newell[1] += (c[2] - n[2]) * (c[0] + n[0]);
        newell[2] += (c[0] - n[0]) * (c[1] + n[1]);
    endfunction

    function automatic void proj_term(input logic [63:0] m [3], input logic [63:0] n [3],
                                      input logic [63:0] p [3]);
        proj[0] += m[1] * (n[2] - p[2]);
        proj[1] += m[0] * (n[2] - p[2]);
        proj[2] += m[0] * (n[1] - p[1]);
    endfunction

    // Closes the face: dominant axis, unit normal, scaled area
    function automatic face_t close_face();
        face_t       f;
        logic [63:0] a [3];
        logic [63:0] r [3];
        logic [63:0] len;
        logic [63:0] mag;
        logic [63:0] q;
        logic [127:0] prod;
        int          ax;
        int          s;
        f = '0;
        f.degenerate = 1'b1;
        f.dominant_axis = AXIS_X;
        for (int i = 0; i < 3; i++)
            a[i] = abs64(newell[i]);
        if (vert_cnt < 3 || (a[0] | a[1] | a[2]) == 0)
            return f;
        ax = 2;
        if (a[0] > a[1])
        begin
            if (a[0] > a[2])
                ax = 0;
        end
        else if (a[1] > a[2])
            ax = 1;
        s = 0;
        while ((a[ax] >> s) >= (64'd1 << 31))
            s++;
        for (int i = 0; i < 3; i++)
            r[i] = a[i] >> s;
        len = isqrt64(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]);
        for (int i = 0; i < 3; i++)
        begin
            mag = ((r[i] << 30) + (len >> 1)) / len;
            mag = newell[i][63] ? mag : -mag;
            case (i)
                0: f.unit_nx = mag[31:0];
                1: f.unit_ny = mag[31:0];
                default: f.unit_nz = mag[31:0];
            endcase
        end
        q = (len << 30) / r[ax];
        prod = 128'(abs64(proj[ax])) * 128'(q);
        prod = prod >> (31 + FRAC);
        f.face_area = (prod > 128'(AREA_SAT)) ? AREA_SAT[47:0] : prod[47:0];
        f.dominant_axis = (ax == 0) ? AXIS_X : (ax == 1) ? AXIS_Y : AXIS_Z;
        f.degenerate = 1'b0;
        return f;
    endfunction

    // Advances the open polygon by one vertex; returns 1 when a face closes
    function automatic bit face_update(input vertex_t v, output face_t f);
        logic [63:0] p [3];
        p[0] = {{32{v.vx[31]}}, v.vx};
        p[1] = {{32{v.vy[31]}}, v.vy};
        p[2] = {{32{v.vz[31]}}, v.vz};
        if (vert_cnt == 0)
            first_pt = p;
        if (vert_cnt == 1)
            second_pt = p;
        if (vert_cnt >= 1)
            edge_term(prev_pt, p);
        if (vert_cnt >= 2)
            proj_term(prev_pt, p, prev2_pt);
        prev2_pt = prev_pt;
        prev_pt = p;
        if (vert_cnt < CNT_SAT)
            vert_cnt++;
        f = '0;
        if (!v.last_vertex)
            return 1'b0;
        if (vert_cnt >= 3)
        begin
            edge_term(p, first_pt);
            proj_term(p, first_pt, prev2_pt);
            proj_term(first_pt, second_pt, p);
        end
        f = close_face();
        clear_face();
        return 1'b1;
    endfunction

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch face %0d %s: got %h want %h", faces_seen, field, got, want);
        errors++;
    endtask

    // Result side: check each transfer, random stall bursts
    always @(posedge clk)
    begin
        face_t want;
        if (rst_n && face_valid && !face_stall)
        begin
            if (face_q.size() == 0)
                report("unexpected", 64'(face), 0);
            else
            begin
                want = face_q.pop_front();
                if (face.face_area != want.face_area)
                    report("face_area", 64'(face.face_area), 64'(want.face_area));
                if (face.unit_nx != want.unit_nx)
                    report("unit_nx", 64'(face.unit_nx), 64'(want.unit_nx));
                if (face.unit_ny != want.unit_ny)
                    report("unit_ny", 64'(face.unit_ny), 64'(want.unit_ny));
                if (face.unit_nz != want.unit_nz)
                    report("unit_nz", 64'(face.unit_nz), 64'(want.unit_nz));
                if (face.dominant_axis != want.dominant_axis)
                    report("dominant_axis", 64'(face.dominant_axis), 64'(want.dominant_axis));
                if (face.degenerate != want.degenerate)
                    report("degenerate", 64'(face.degenerate), 64'(want.degenerate));
                if (want.degenerate)
                    degen_seen++;
            end
            faces_seen++;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            face_stall <= 1'b1;
        end
        else if (rst_n && idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            face_stall <= 1'b1;
        end
        else
            face_stall <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One vertex transfer; expected face is the typed one when given
    task automatic send_vertex(input vertex_t v, input bit typed, input face_t typed_face);
        face_t f;
        vert <= v;
        vert_valid <= 1'b1;
        @(posedge clk);
        while (vert_stall)
            @(posedge clk);
        verts_sent++;
        if (face_update(v, f))
            face_q.push_back(typed ? typed_face : f);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            vert_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_faces();
        vert_valid <= 1'b0;
        @(posedge clk);
        while (face_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic vertex_t pt(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input bit last);
        vertex_t v;
        v.vx = x;
        v.vy = y;
        v.vz = z;
        v.last_vertex = last;
        return v;
    endfunction

    // Random coordinate sign-extended from its low span bits
    function automatic logic [31:0] rand_coord(input int span);
        logic [31:0] c;
        c = $urandom;
        if (span < 32)
            c = 32'($signed(c << (32 - span)) >>> (32 - span));
        return c;
    endfunction

    typedef struct {
        vertex_t v;
        bit      typed;
        face_t   f;
    } stim_row_t;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] NONE = 32'hFFFF_0000;
    localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [31:0] MINC = 32'h8000_0000;

    initial
    begin
        stim_row_t rows [$];
        face_t     degen;
        face_t     none;
        vertex_t   v;
        int        nv;
        int        span;
        int        flat_axis;
        int        sel;
        logic [31:0] flat_val;
        logic [31:0] c [3];

        clear_face();
        none = '0;
        degen = '0;
        degen.degenerate = 1'b1;
        degen.dominant_axis = AXIS_X;

        // Directed stimulus: short faces, collinear, ties, extremes
        rows.push_back('{pt(ONE, ONE, ONE, 1), 1, degen});
        rows.push_back('{pt(0, 0, 0, 0), 0, none});
        rows.push_back('{pt(ONE, 0, 0, 1), 1, degen});
        rows.push_back('{pt(0, 0, 0, 0), 0, none});
        rows.push_back('{pt(ONE, ONE, ONE, 0), 0, none});
        rows.push_back('{pt(2 * ONE, 2 * ONE, 2 * ONE, 1), 1, degen});
        rows.push_back('{pt(0, 0, 0, 0), 0, none});
        rows.push_back('{pt(ONE, 0, 0, 0), 0, none});
        rows.push_back('{pt(0, ONE, 0, 1), 0, none});
        rows.push_back('{pt(ONE, 0, 0, 0), 0, none});
        rows.push_back('{pt(0, ONE, 0, 0), 0, none});
        rows.push_back('{pt(0, 0, ONE, 1), 0, none});
        rows.push_back('{pt(0, 0, 0, 0), 0, none});
        rows.push_back('{pt(ONE, ONE, 0, 0), 0, none});
        rows.push_back('{pt(NONE, ONE, 2 * ONE, 1), 0, none});
        rows.push_back('{pt(MAXC, MINC, MAXC, 0), 0, none});
        rows.push_back('{pt(MINC, MAXC, MINC, 0), 0, none});
        rows.push_back('{pt(MAXC, MAXC, MINC, 0), 0, none});
        rows.push_back('{pt(MINC, MINC, MAXC, 1), 0, none});
        rows.push_back('{pt(MAXC, 0, 0, 0), 0, none});
        rows.push_back('{pt(0, MAXC, 0, 0), 0, none});
        rows.push_back('{pt(0, 0, MAXC, 0), 0, none});
        rows.push_back('{pt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 0, none});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_vertex(rows[i].v, rows[i].typed, rows[i].f);
        drain_faces();

        // Random polygons, mostly well formed, sized and scaled at random
        while (verts_sent < RAND_ITEMS)
        begin
            if (verts_sent > RAND_ITEMS - 200)
                idle_on = 1'b0;
            if (verts_sent > RAND_ITEMS / 2 && verts_sent < RAND_ITEMS / 2 + 20)
                drain_faces();
            sel = $urandom_range(0, 99);
            nv = (sel < 70) ? $urandom_range(3, 8) : (sel < 80) ? $urandom_range(1, 2) :
                 (sel < 95) ? $urandom_range(9, 20) : $urandom_range(40, 64);
            sel = $urandom_range(0, 3);
            span = (sel == 0) ? 32 : (sel == 1) ? 20 : (sel == 2) ? 26 : 8;
            flat_axis = $urandom_range(0, 5);
            flat_val = rand_coord(span);
            for (int k = 0; k < nv; k++)
            begin
                for (int j = 0; j < 3; j++)
                    c[j] = (j == flat_axis) ? flat_val : rand_coord(span);
                if (k > 0 && $urandom_range(0, 19) == 0)
                    c = '{vert.vx, vert.vy, vert.vz};
                v = pt(c[0], c[1], c[2], k == nv - 1);
                send_vertex(v, 1'b0, none);
            end
        end

        drain_faces();
        repeat (300) @(posedge clk);
        $display("sent %0d vertices, checked %0d faces (%0d degenerate)",
                 verts_sent, faces_seen, degen_seen);
        if (errors == 0 && face_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
